/* hw/rtl/rvid_pkg.sv */
// Opcodes, field constants and operation codes for the RV32I subset decoder.
package rvid_pkg;

    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;

    localparam logic [6:0]  F7_ALT     = 7'h20;
    localparam logic [31:0] SHAMT_MASK = 32'h0000_001F;
    localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRL  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;

    typedef enum logic [4:0] {
        OP_ADD     = 5'd0,
        OP_SUB     = 5'd1,
        OP_SLL     = 5'd2,
        OP_XOR     = 5'd3,
        OP_SRL     = 5'd4,
        OP_SRA     = 5'd5,
        OP_OR      = 5'd6,
        OP_AND     = 5'd7,
        OP_ADDI    = 5'd8,
        OP_SLLI    = 5'd9,
        OP_SRLI    = 5'd10,
        OP_SRAI    = 5'd11,
        OP_ORI     = 5'd12,
        OP_ANDI    = 5'd13,
        OP_LW      = 5'd14,
        OP_SW      = 5'd15,
        OP_BEQ     = 5'd16,
        OP_BNE     = 5'd17,
        OP_LUI     = 5'd18,
        OP_JAL     = 5'd19,
        OP_JALR    = 5'd20,
        OP_UNSUP   = 5'd21,
        OP_UNKNOWN = 5'd22
    } op_t;

endpackage

/* hw/rtl/rv32i_instruction_decoder.sv */
// RV32I subset instruction decoder: input register, decode logic, result register.
// An accepted word is registered in word_reg, decoded, and the result is registered together with done_reg.
// Throughput: one instruction per cycle; busy is always low, the decode path is one stage.
// The receiver cannot stall: each result shows for exactly one cycle with done high.
// Reset (rst_n low, asynchronous) clears the stage valid flags; an instruction in flight then gives no done.
module rv32i_instruction_decoder
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        instr_word,
    output logic               done,
    output logic [4:0]         operation,
    output logic [4:0]         dest_reg,
    output logic [4:0]         src1_reg,
    output logic [4:0]         src2_reg,
    output logic signed [31:0] immediate
);

    logic        in_valid_reg;
    logic [31:0] word_reg;
    logic        done_reg;
    logic [4:0]  op_reg;
    logic [4:0]  rd_reg;
    logic [4:0]  rs1_reg;
    logic [4:0]  rs2_reg;
    logic [31:0] imm_reg;

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic        alt;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_u;
    logic [31:0] imm_j;
    logic [31:0] imm_sh;
    rvid_pkg::op_t op_next;
    logic [31:0] imm_next;

    assign busy = 1'b0;

    assign opc   = word_reg[6:0];
    assign f3    = word_reg[14:12];
    assign alt   = (word_reg[31:25] == rvid_pkg::F7_ALT);
    assign imm_i = {{20{word_reg[31]}}, word_reg[31:20]};
    assign imm_s = {{20{word_reg[31]}}, word_reg[31:25], word_reg[11:7]};
    assign imm_b = {{19{word_reg[31]}}, word_reg[31], word_reg[7], word_reg[30:25],
                    word_reg[11:8], 1'b0};
    assign imm_u = word_reg & rvid_pkg::UPPER_MASK;
    assign imm_j = {{11{word_reg[31]}}, word_reg[31], word_reg[19:12], word_reg[20],
                    word_reg[30:21], 1'b0};
    assign imm_sh = imm_i & rvid_pkg::SHAMT_MASK;

    always_comb
    begin
        op_next  = rvid_pkg::OP_UNSUP;
        imm_next = 32'd0;
        unique case (opc)
            rvid_pkg::OPC_OP:
            begin
                unique case (f3)
                    rvid_pkg::F3_ADD: op_next = alt ? rvid_pkg::OP_SUB : rvid_pkg::OP_ADD;
                    rvid_pkg::F3_SLL: op_next = rvid_pkg::OP_SLL;
                    rvid_pkg::F3_XOR: op_next = rvid_pkg::OP_XOR;
                    rvid_pkg::F3_SRL: op_next = alt ? rvid_pkg::OP_SRA : rvid_pkg::OP_SRL;
                    rvid_pkg::F3_OR:  op_next = rvid_pkg::OP_OR;
                    rvid_pkg::F3_AND: op_next = rvid_pkg::OP_AND;
                    default:          op_next = rvid_pkg::OP_UNSUP;
                endcase
            end
            rvid_pkg::OPC_OPIMM:
            begin
                unique case (f3)
                    rvid_pkg::F3_ADD:
                    begin
                        op_next  = rvid_pkg::OP_ADDI;
                        imm_next = imm_i;
                    end
                    rvid_pkg::F3_SLL:
                    begin
                        op_next  = rvid_pkg::OP_SLLI;
                        imm_next = imm_sh;
                    end
                    rvid_pkg::F3_SRL:
                    begin
                        op_next  = alt ? rvid_pkg::OP_SRAI : rvid_pkg::OP_SRLI;
                        imm_next = imm_sh;
                    end
                    rvid_pkg::F3_OR:
                    begin
                        op_next  = rvid_pkg::OP_ORI;
                        imm_next = imm_i;
                    end
                    rvid_pkg::F3_AND:
                    begin
                        op_next  = rvid_pkg::OP_ANDI;
                        imm_next = imm_i;
                    end
                    default:
                    begin
                        op_next  = rvid_pkg::OP_UNSUP;
                        imm_next = 32'd0;
                    end
                endcase
            end
            rvid_pkg::OPC_LOAD:
            begin
                if (f3 == rvid_pkg::F3_WORD)
                begin
                    op_next  = rvid_pkg::OP_LW;
                    imm_next = imm_i;
                end
            end
            rvid_pkg::OPC_STORE:
            begin
                if (f3 == rvid_pkg::F3_WORD)
                begin
                    op_next  = rvid_pkg::OP_SW;
                    imm_next = imm_s;
                end
            end
            rvid_pkg::OPC_BRANCH:
            begin
                if (f3 == rvid_pkg::F3_BEQ)
                begin
                    op_next  = rvid_pkg::OP_BEQ;
                    imm_next = imm_b;
                end
                else if (f3 == rvid_pkg::F3_BNE)
                begin
                    op_next  = rvid_pkg::OP_BNE;
                    imm_next = imm_b;
                end
            end
            rvid_pkg::OPC_LUI:
            begin
                op_next  = rvid_pkg::OP_LUI;
                imm_next = imm_u;
            end
            rvid_pkg::OPC_JAL:
            begin
                op_next  = rvid_pkg::OP_JAL;
                imm_next = imm_j;
            end
            rvid_pkg::OPC_JALR:
            begin
                op_next  = rvid_pkg::OP_JALR;
                imm_next = imm_i;
            end
            default:
            begin
                op_next  = rvid_pkg::OP_UNKNOWN;
                imm_next = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            word_reg <= instr_word;
        end
        if (in_valid_reg)
        begin
            op_reg  <= op_next;
            rd_reg  <= word_reg[11:7];
            rs1_reg <= word_reg[19:15];
            rs2_reg <= word_reg[24:20];
            imm_reg <= imm_next;
        end
    end

    assign done      = done_reg;
    assign operation = op_reg;
    assign dest_reg  = rd_reg;
    assign src1_reg  = rs1_reg;
    assign src2_reg  = rs2_reg;
    assign immediate = imm_reg;

    a_accept_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> in_valid_reg)
        else $error("accepted beat did not reach the decode stage");

    a_decode_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |=> done)
        else $error("decoded beat did not produce a done strobe");

    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_valid_reg))
        else $error("done strobe without a decoded beat");

    a_lui_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && operation == rvid_pkg::OP_LUI) |-> (immediate[11:0] == 12'd0))
        else $error("lui immediate has nonzero low bits");

    a_shamt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (operation == rvid_pkg::OP_SLLI || operation == rvid_pkg::OP_SRLI ||
                  operation == rvid_pkg::OP_SRAI)) |-> (immediate[31:5] == 27'd0))
        else $error("shift amount exceeds five bits");

    a_no_imm_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (operation == rvid_pkg::OP_UNSUP || operation == rvid_pkg::OP_UNKNOWN))
        |-> (immediate == 32'sd0))
        else $error("immediate not cleared for unsupported or unknown instruction");

endmodule
